/* sv/binary_lifting_lca_core_defines.svh */
// Assertion macros for the binary-lifting LCA core.
// Macros expand to nothing when SYNTHESIS is defined.
`ifndef BINARY_LIFTING_LCA_CORE_DEFINES_SVH
`define BINARY_LIFTING_LCA_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BLL_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define BLL_ASSERT_NXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BLL_ASSERT_IMP(name, clk, rst, pre, post, msg)
`define BLL_ASSERT_NXT(name, clk, rst, pre, post, msg)
`endif
`endif

/* sv/bll_pkg.sv */
// Shared constants and types for the binary-lifting LCA core.
// No dependencies.
`default_nettype none
package bll_pkg;

   localparam int BLL_MAX_NODES  = 1024;
   localparam int BLL_LOG_LEVELS = 14;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_BUILD = 2'd1,
      REQ_ANC   = 2'd2,
      REQ_LCA   = 2'd3
   } req_code_type;

endpackage
`default_nettype wire

/* sv/bll_lift_mem.sv */
// Lift table storage: one write port, two registered read ports.
// Depends on bll_pkg for default sizes.
`default_nettype none
module bll_lift_mem import bll_pkg::*; #(
   parameter int MAX_NODES  = BLL_MAX_NODES,
   parameter int LOG_LEVELS = BLL_LOG_LEVELS,
   localparam int NODE_W    = $clog2(MAX_NODES),
   localparam int LVL_W     = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [LVL_W-1:0]  wr_lvl,
   input  wire logic [NODE_W-1:0] wr_node,
   input  wire logic [NODE_W-1:0] wr_data,
   input  wire logic [LVL_W-1:0]  rd_a_lvl,
   input  wire logic [NODE_W-1:0] rd_a_node,
   output logic      [NODE_W-1:0] rd_a_data,
   input  wire logic [LVL_W-1:0]  rd_b_lvl,
   input  wire logic [NODE_W-1:0] rd_b_node,
   output logic      [NODE_W-1:0] rd_b_data
);

   logic [NODE_W-1:0] mem [LOG_LEVELS][MAX_NODES];
   logic [NODE_W-1:0] rd_a_ff;
   logic [NODE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_lvl][wr_node] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_lvl][rd_a_node];
      rd_b_ff <= mem[rd_b_lvl][rd_b_node];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

/* sv/binary_lifting_lca_core.sv */
// Load writes the table and depth store directly; build walks level 0, then each higher level;
// an ancestor query climbs the set bits of step_count into the result register; an lca query
// reads both depths, climbs the deeper node, then lifts both nodes level by level, ending early
// if the climbed nodes meet. One item at a time, paced by table reads.
// Synchronous reset clears control and sets node_count to MAX_NODES; table and depth
// storage are undefined until loaded and built, with no clearing pass.
`default_nettype none
`include "binary_lifting_lca_core_defines.svh"
module binary_lifting_lca_core import bll_pkg::*; #(
   parameter int MAX_NODES  = BLL_MAX_NODES,
   parameter int LOG_LEVELS = BLL_LOG_LEVELS,
   localparam int NODE_W    = $clog2(MAX_NODES),
   localparam int CNT_W     = NODE_W + 1,
   localparam int STEP_W    = LOG_LEVELS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic [NODE_W-1:0] req_node_a,
   input  wire logic [NODE_W-1:0] req_node_b,
   input  wire logic [NODE_W-1:0] req_parent_node,
   input  wire logic [NODE_W-1:0] req_node_depth,
   input  wire logic [STEP_W-1:0] req_step_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [NODE_W-1:0] rsp_result_node,
   input  wire logic              csr_wr_en,
   input  wire logic [CNT_W-1:0]  csr_wr_data
);

   localparam int LVL_W = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LOG_LEVELS - 1);

   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_B0_RD    = 17'h00002,
      ST_B0_WR    = 17'h00004,
      ST_BK_RD    = 17'h00008,
      ST_BK_MID   = 17'h00010,
      ST_BK_WR    = 17'h00020,
      ST_DEP_A    = 17'h00040,
      ST_DEP_B    = 17'h00080,
      ST_DIFF     = 17'h00100,
      ST_CLIMB    = 17'h00200,
      ST_CLIMB_WT = 17'h00400,
      ST_CEND     = 17'h00800,
      ST_LIFT_RD  = 17'h01000,
      ST_LIFT_WT  = 17'h02000,
      ST_FIN_RD   = 17'h04000,
      ST_FIN_WT   = 17'h08000,
      ST_DONE     = 17'h10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff, node_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic              mode_lca_ff, mode_lca_in;
   logic              swap_ff, swap_in;
   logic [NODE_W-1:0] u_ff, u_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [NODE_W-1:0] c_ff, c_in;
   logic [NODE_W-1:0] x_ff, x_in;
   logic [NODE_W-1:0] du_ff, du_in;
   logic [NODE_W-1:0] res_ff, res_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;

   logic [CNT_W-1:0]  n_act;
   logic [CNT_W-1:0]  n_last;
   logic              a_ok, b_ok, x_last;
   logic              accept;
   logic [NODE_W-1:0] diff;
   logic [STEP_W+NODE_W-1:0] diff_ext;
   logic [NODE_W-1:0] cu, cv;

   logic              tbl_we;
   logic [LVL_W-1:0]  tbl_wlvl;
   logic [NODE_W-1:0] tbl_wnode, tbl_wdata;
   logic [LVL_W-1:0]  ra_lvl, rb_lvl;
   logic [NODE_W-1:0] ra_node, rb_node;
   logic [NODE_W-1:0] rd_a, rd_b;
   logic [CNT_W-1:0]  wnode_ext;
   logic [CNT_W-1:0]  rd_a_ext;

   logic              dep_we;
   logic [NODE_W-1:0] dep_ra;
   logic [NODE_W-1:0] dep_mem [MAX_NODES];
   logic [NODE_W-1:0] dep_rd_ff;

   bll_lift_mem #(
      .MAX_NODES  (MAX_NODES),
      .LOG_LEVELS (LOG_LEVELS)
   ) u_lift_mem (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_lvl    (tbl_wlvl),
      .wr_node   (tbl_wnode),
      .wr_data   (tbl_wdata),
      .rd_a_lvl  (ra_lvl),
      .rd_a_node (ra_node),
      .rd_a_data (rd_a),
      .rd_b_lvl  (rb_lvl),
      .rd_b_node (rb_node),
      .rd_b_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[req_node_a] <= req_node_depth;
      end
      dep_rd_ff <= dep_mem[dep_ra];
   end

   always_comb begin
      if (node_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_act = CNT_W'(MAX_NODES);
      end else begin
         n_act = node_count_ff;
      end
   end

   assign n_last    = n_act - CNT_W'(1);
   assign a_ok      = CNT_W'(req_node_a) < n_act;
   assign b_ok      = CNT_W'(req_node_b) < n_act;
   assign x_last    = CNT_W'(x_ff) == n_last;
   assign rd_a_ext  = CNT_W'(rd_a);
   assign wnode_ext = CNT_W'(tbl_wnode);
   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign diff      = (du_ff < dep_rd_ff) ? (dep_rd_ff - du_ff) : (du_ff - dep_rd_ff);
   assign diff_ext  = (STEP_W+NODE_W)'(diff);
   assign cu        = swap_ff ? u_ff : c_ff;
   assign cv        = swap_ff ? c_ff : v_ff;

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_node_in   = rsp_node_ff;
      mode_lca_in   = mode_lca_ff;
      swap_in       = swap_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      c_in          = c_ff;
      x_in          = x_ff;
      du_in         = du_ff;
      res_in        = res_ff;
      steps_in      = steps_ff;
      lvl_in        = lvl_ff;
      tbl_we        = 1'b0;
      tbl_wlvl      = '0;
      tbl_wnode     = x_ff;
      tbl_wdata     = x_ff;
      ra_lvl        = '0;
      ra_node       = '0;
      rb_lvl        = lvl_ff;
      rb_node       = v_ff;
      dep_we        = 1'b0;
      dep_ra        = u_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code_type'(req_type))
                  REQ_LOAD: begin
                     if (a_ok) begin
                        tbl_we    = 1'b1;
                        tbl_wnode = req_node_a;
                        tbl_wdata = req_parent_node;
                        dep_we    = 1'b1;
                     end
                  end
                  REQ_BUILD: begin
                     x_in     = '0;
                     state_in = ST_B0_RD;
                  end
                  REQ_ANC: begin
                     if (a_ok) begin
                        c_in        = req_node_a;
                        steps_in    = req_step_count;
                        lvl_in      = LVL_LAST;
                        mode_lca_in = 1'b0;
                        state_in    = ST_CLIMB;
                     end
                  end
                  REQ_LCA: begin
                     if (a_ok && b_ok) begin
                        u_in        = req_node_a;
                        v_in        = req_node_b;
                        mode_lca_in = 1'b1;
                        state_in    = ST_DEP_A;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_B0_RD: begin
            ra_node  = x_ff;
            state_in = ST_B0_WR;
         end
         ST_B0_WR: begin
            // a parent outside the active range turns the node into a root
            if (rd_a_ext >= n_act) begin
               tbl_we = 1'b1;
            end
            if (x_last) begin
               x_in     = '0;
               lvl_in   = LVL_W'(1);
               state_in = (LOG_LEVELS > 1) ? ST_BK_RD : ST_IDLE;
            end else begin
               x_in     = x_ff + NODE_W'(1);
               state_in = ST_B0_RD;
            end
         end
         ST_BK_RD: begin
            ra_lvl   = lvl_ff - LVL_W'(1);
            ra_node  = x_ff;
            state_in = ST_BK_MID;
         end
         ST_BK_MID: begin
            ra_lvl   = lvl_ff - LVL_W'(1);
            ra_node  = rd_a;
            state_in = ST_BK_WR;
         end
         ST_BK_WR: begin
            tbl_we    = 1'b1;
            tbl_wlvl  = lvl_ff;
            tbl_wdata = rd_a;
            if (x_last) begin
               x_in = '0;
               if (lvl_ff == LVL_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in   = lvl_ff + LVL_W'(1);
                  state_in = ST_BK_RD;
               end
            end else begin
               x_in     = x_ff + NODE_W'(1);
               state_in = ST_BK_RD;
            end
         end
         ST_DEP_A: begin
            dep_ra   = u_ff;
            state_in = ST_DEP_B;
         end
         ST_DEP_B: begin
            dep_ra   = v_ff;
            du_in    = dep_rd_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // climb the deeper node by the depth difference
            swap_in  = du_ff < dep_rd_ff;
            c_in     = (du_ff < dep_rd_ff) ? v_ff : u_ff;
            steps_in = diff_ext[STEP_W-1:0];
            lvl_in   = LVL_LAST;
            state_in = ST_CLIMB;
         end
         ST_CLIMB: begin
            ra_lvl  = lvl_ff;
            ra_node = c_ff;
            if (steps_ff[lvl_ff]) begin
               state_in = ST_CLIMB_WT;
            end else if (lvl_ff == '0) begin
               state_in = ST_CEND;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         ST_CLIMB_WT: begin
            c_in = rd_a;
            if (lvl_ff == '0) begin
               state_in = ST_CEND;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = ST_CLIMB;
            end
         end
         ST_CEND: begin
            if (!mode_lca_ff) begin
               res_in   = c_ff;
               state_in = ST_DONE;
            end else begin
               u_in = cu;
               v_in = cv;
               if (cu == cv) begin
                  res_in   = cu;
                  state_in = ST_DONE;
               end else begin
                  lvl_in   = LVL_LAST;
                  state_in = ST_LIFT_RD;
               end
            end
         end
         ST_LIFT_RD: begin
            ra_lvl   = lvl_ff;
            ra_node  = u_ff;
            rb_lvl   = lvl_ff;
            rb_node  = v_ff;
            state_in = ST_LIFT_WT;
         end
         ST_LIFT_WT: begin
            if (rd_a != rd_b) begin
               u_in = rd_a;
               v_in = rd_b;
            end
            if (lvl_ff == '0) begin
               state_in = ST_FIN_RD;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = ST_LIFT_RD;
            end
         end
         ST_FIN_RD: begin
            ra_node  = u_ff;
            state_in = ST_FIN_WT;
         end
         ST_FIN_WT: begin
            res_in   = rd_a;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= CNT_W'(MAX_NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_node_ff <= rsp_node_in;
      mode_lca_ff <= mode_lca_in;
      swap_ff     <= swap_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      c_ff        <= c_in;
      x_ff        <= x_in;
      du_ff       <= du_in;
      res_ff      <= res_in;
      steps_ff    <= steps_in;
      lvl_ff      <= lvl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = rsp_node_ff;

   `BLL_ASSERT_IMP(a_wr_in_range, clock, reset, tbl_we, wnode_ext < n_act, "table write beyond active nodes")
   `BLL_ASSERT_NXT(a_done_hold, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE, "result dropped while output full")
   `BLL_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result raised outside done state")

endmodule
`default_nettype wire

/* bench/binary_lifting_lca_checker.sv */
// Transfer monitor and result predictor for binary_lifting_lca_core.
// Tracks node_count, the lift table and node depths; compares each result in order.
// Depends on bll_pkg.
module binary_lifting_lca_checker import bll_pkg::*; #(
   parameter int NODE_W = $clog2(BLL_MAX_NODES),
   parameter int STEP_W = BLL_LOG_LEVELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   input  logic [NODE_W-1:0] req_parent_node,
   input  logic [NODE_W-1:0] req_node_depth,
   input  logic [STEP_W-1:0] req_step_count,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [NODE_W-1:0] rsp_result_node,
   input  logic              csr_wr_en,
   input  logic [NODE_W:0]   csr_wr_data,
   output int                failures,
   output int                waiting
);

   logic [NODE_W-1:0] lift [BLL_LOG_LEVELS][BLL_MAX_NODES];
   logic [NODE_W-1:0] depth_mem [BLL_MAX_NODES];
   logic [NODE_W:0]   node_count_q;
   logic [NODE_W-1:0] expected_nodes [$];
   logic [NODE_W-1:0] want;

   function automatic int unsigned nodes_in_use();
      if (node_count_q == 0) return 1;
      if (node_count_q > BLL_MAX_NODES) return BLL_MAX_NODES;
      return node_count_q;
   endfunction

   function automatic logic [NODE_W-1:0] climb_up(logic [NODE_W-1:0] start,
                                                  logic [STEP_W-1:0] steps);
      logic [NODE_W-1:0] x;
      x = start;
      for (int k = STEP_W - 1; k >= 0; k--) begin
         if (steps[k]) x = lift[k][x];
      end
      return x;
   endfunction

   function automatic void fill_lift_table();
      int unsigned n;
      n = nodes_in_use();
      for (int unsigned x = 0; x < n; x++) begin
         if (lift[0][x] >= n) lift[0][x] = NODE_W'(x);
      end
      for (int k = 1; k < STEP_W; k++) begin
         for (int unsigned x = 0; x < n; x++) begin
            lift[k][x] = lift[k-1][lift[k-1][x]];
         end
      end
   endfunction

   function automatic logic [NODE_W-1:0] lowest_common(logic [NODE_W-1:0] u,
                                                       logic [NODE_W-1:0] v);
      logic [NODE_W-1:0] du, dv, level, x, y;
      du = depth_mem[u];
      dv = depth_mem[v];
      level = (du < dv) ? du : dv;
      x = climb_up(u, STEP_W'(du - level));
      y = climb_up(v, STEP_W'(dv - level));
      if (x == y) return x;
      for (int k = STEP_W - 1; k >= 0; k--) begin
         if (lift[k][x] != lift[k][y]) begin
            x = lift[k][x];
            y = lift[k][y];
         end
      end
      return lift[0][x];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BLL_LOG_LEVELS; k++) begin
            for (int x = 0; x < BLL_MAX_NODES; x++) lift[k][x] = '0;
         end
         for (int x = 0; x < BLL_MAX_NODES; x++) depth_mem[x] = '0;
         node_count_q = BLL_MAX_NODES;
         expected_nodes.delete();
         failures <= 0;
         waiting <= 0;
      end else begin
         if (csr_wr_en) node_count_q = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_nodes.size() == 0) begin
               $error("result_node: expected none, actual %0d", rsp_result_node);
               failures <= failures + 1;
            end else begin
               want = expected_nodes.pop_front();
               if (want !== rsp_result_node) begin
                  $error("result_node: expected %0d, actual %0d", want, rsp_result_node);
                  failures <= failures + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_code_type'(req_type))
               REQ_LOAD: begin
                  if (req_node_a < nodes_in_use()) begin
                     lift[0][req_node_a] = req_parent_node;
                     depth_mem[req_node_a] = req_node_depth;
                  end
               end
               REQ_BUILD: begin
                  fill_lift_table();
               end
               REQ_ANC: begin
                  if (req_node_a < nodes_in_use())
                     expected_nodes.push_back(climb_up(req_node_a, req_step_count));
               end
               REQ_LCA: begin
                  if (req_node_a < nodes_in_use() && req_node_b < nodes_in_use())
                     expected_nodes.push_back(lowest_common(req_node_a, req_node_b));
               end
            endcase
         end
         waiting <= expected_nodes.size();
      end
   end

endmodule

/* bench/binary_lifting_lca_core_tb.sv */
// Top-level bench for binary_lifting_lca_core: clock, reset, request and node_count
// stimulus, response back-pressure, watchdog and verdict.
// Depends on bll_pkg, binary_lifting_lca_core and binary_lifting_lca_checker.
module binary_lifting_lca_core_tb;
   import bll_pkg::*;

   localparam int NODE_W      = $clog2(BLL_MAX_NODES);
   localparam int STEP_W      = BLL_LOG_LEVELS;
   localparam int CNT_W       = NODE_W + 1;
   localparam int QUIET_LIMIT = 25000;
   localparam int ITEM_GOAL   = 450;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_type;
   logic [NODE_W-1:0] req_node_a;
   logic [NODE_W-1:0] req_node_b;
   logic [NODE_W-1:0] req_parent_node;
   logic [NODE_W-1:0] req_node_depth;
   logic [STEP_W-1:0] req_step_count;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [NODE_W-1:0] rsp_result_node;
   logic              csr_wr_en;
   logic [CNT_W-1:0]  csr_wr_data;

   int          fail_count;
   int          outstanding;
   int unsigned quiet = 0;
   int unsigned next_gap = 0;
   int unsigned active_n = BLL_MAX_NODES;
   int unsigned last_build_n = 0;
   int unsigned built_top = 0;
   int unsigned random_items = 0;
   int unsigned depth_of [BLL_MAX_NODES];
   bit          offer_open = 0;
   bit          sender_burst = 0;
   bit          squeeze_rsp = 0;

   binary_lifting_lca_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_node (req_parent_node),
      .req_node_depth  (req_node_depth),
      .req_step_count  (req_step_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_node (rsp_result_node),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   binary_lifting_lca_checker u_result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_node (req_parent_node),
      .req_node_depth  (req_node_depth),
      .req_step_count  (req_step_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_node (rsp_result_node),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failures        (fail_count),
      .waiting         (outstanding)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send(req_code_type kind, int unsigned a, int unsigned b,
                       int unsigned parent, int unsigned depth, int unsigned steps);
      repeat (next_gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_node_a      <= NODE_W'(a);
      req_node_b      <= NODE_W'(b);
      req_parent_node <= NODE_W'(parent);
      req_node_depth  <= NODE_W'(depth);
      req_step_count  <= STEP_W'(steps);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      next_gap = sender_burst ? 0 : $urandom_range(0, 6);
      offer_open = (next_gap == 0);
      if (!offer_open) req_valid <= 1'b0;
      if (kind == REQ_LOAD && NODE_W'(a) < active_n) depth_of[NODE_W'(a)] = NODE_W'(depth);
      if (kind == REQ_BUILD) begin
         last_build_n = active_n;
         if (active_n > built_top) built_top = active_n;
      end
   endtask

   task automatic release_sender();
      if (offer_open) begin
         req_valid <= 1'b0;
         offer_open = 0;
      end
   endtask

   // drain results, then allow for a build still in progress
   task automatic settle();
      release_sender();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (41 * last_build_n + 100) @(posedge clock);
   endtask

   task automatic write_node_count(int unsigned value);
      int unsigned v;
      settle();
      v = value % 2048;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_n = (v == 0) ? 1 : ((v > BLL_MAX_NODES) ? BLL_MAX_NODES : v);
   endtask

   function automatic int unsigned pick_steps(int unsigned a);
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 16383);
      return $urandom_range(0, depth_of[a] + 2);
   endfunction

   task automatic query_some(int unsigned count, int unsigned span);
      int unsigned a, b, off;
      bit lca;
      for (int i = 0; i < count; i++) begin
         a = $urandom_range(0, span - 1);
         b = $urandom_range(0, span - 1);
         lca = $urandom_range(0, 1);
         if (active_n < BLL_MAX_NODES && $urandom_range(0, 11) == 0) begin
            off = $urandom_range(active_n, BLL_MAX_NODES - 1);
            if ($urandom_range(0, 1)) a = off;
            else b = off;
         end
         if (lca) send(REQ_LCA, a, b, $urandom, $urandom, $urandom);
         else send(REQ_ANC, a, b, $urandom, $urandom, pick_steps(a));
         if (a < active_n && !(lca && b >= active_n)) random_items++;
      end
   endtask

   task automatic tree_phase();
      int unsigned n, shape, par, dep, x;
      case ($urandom_range(0, 9))
         0: n = 1;
         1: n = $urandom_range(40, 48);
         default: n = $urandom_range(2, 20);
      endcase
      write_node_count((n == 1 && $urandom_range(0, 1)) ? 0 : n);
      shape = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) begin
         if (shape == 0) begin
            par = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
            dep = $urandom_range(0, 1023);
         end else if (i == 0 || $urandom_range(0, 15) == 0) begin
            par = i;
            dep = 0;
         end else begin
            par = $urandom_range(0, i - 1);
            dep = depth_of[par] + 1;
         end
         send(REQ_LOAD, i, $urandom, par, dep, $urandom);
         random_items++;
         if (n < BLL_MAX_NODES && $urandom_range(0, 9) == 0)
            send(REQ_LOAD, $urandom_range(n, 1023), $urandom, $urandom, $urandom, $urandom);
      end
      send(REQ_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_items++;
      squeeze_rsp = 1;
      query_some($urandom_range(10, 30), n);
      if ($urandom_range(0, 4) == 0) begin
         x = $urandom_range(0, n - 1);
         send(REQ_LOAD, x, $urandom, $urandom_range(0, n - 1), $urandom_range(0, 1023), $urandom);
         random_items++;
         query_some(5, n);
         if ($urandom_range(0, 1)) begin
            send(REQ_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
            random_items++;
            query_some(5, n);
         end
      end
   endtask

   // full node range: load only beyond the built nodes, query only built ones
   task automatic wide_phase(bit top_code);
      int unsigned v;
      case ($urandom_range(0, 2))
         0: v = 1024;
         1: v = 2047;
         default: v = $urandom_range(1025, 2046);
      endcase
      write_node_count(top_code ? 2047 : v);
      repeat ($urandom_range(6, 14)) begin
         send(REQ_LOAD, $urandom_range(built_top, 1023), $urandom, $urandom, $urandom,
              $urandom);
         random_items++;
      end
      query_some($urandom_range(8, 16), built_top);
   endtask

   // shrink node_count without a rebuild; table entries may point past it
   task automatic shrink_phase();
      write_node_count($urandom_range(1, last_build_n - 1));
      query_some($urandom_range(6, 12), active_n);
   endtask

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      begin : receiver
         int unsigned stall, taken;
         bit calm, squeezed;
         taken = 0;
         calm = 0;
         squeezed = 0;
         forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (squeeze_rsp && !squeezed) begin
               stall = 400;
               squeezed = 1;
            end
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            taken++;
            if (taken % 25 == 0) calm = ($urandom_range(0, 3) == 0);
         end
      end
   end

   initial begin
      int unsigned pick, phase_no;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_LOAD;
      req_node_a      <= '0;
      req_node_b      <= '0;
      req_parent_node <= '0;
      req_node_depth  <= '0;
      req_step_count  <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single node: count of zero acts as one
      write_node_count(0);
      send(REQ_LOAD, 0, $urandom, 0, 0, $urandom);
      send(REQ_LOAD, 1, $urandom, $urandom, $urandom, $urandom);
      send(REQ_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
      send(REQ_ANC, 0, $urandom, $urandom, $urandom, 16383);
      send(REQ_LCA, 0, 0, $urandom, $urandom, $urandom);
      send(REQ_ANC, 1023, $urandom, $urandom, $urandom, 1);

      // small tree plus a node whose parent is out of range
      write_node_count(5);
      send(REQ_LOAD, 0, $urandom, 0, 0, $urandom);
      send(REQ_LOAD, 1, $urandom, 0, 1, $urandom);
      send(REQ_LOAD, 2, $urandom, 1, 2, $urandom);
      send(REQ_LOAD, 3, $urandom, 0, 1, $urandom);
      send(REQ_LOAD, 4, $urandom, 1023, 0, $urandom);
      send(REQ_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
      send(REQ_ANC, 2, $urandom, $urandom, $urandom, 1);
      send(REQ_ANC, 2, $urandom, $urandom, $urandom, 2);
      send(REQ_ANC, 2, $urandom, $urandom, $urandom, 16383);
      send(REQ_ANC, 4, $urandom, $urandom, $urandom, 3);
      send(REQ_LCA, 2, 3, $urandom, $urandom, $urandom);
      send(REQ_LCA, 1, 2, $urandom, $urandom, $urandom);
      send(REQ_LCA, 4, 2, $urandom, $urandom, $urandom);
      send(REQ_LCA, 3, 3, $urandom, $urandom, $urandom);
      send(REQ_LCA, 2, 1023, $urandom, $urandom, $urandom);
      send(REQ_LOAD, 1023, 1023, 1023, 1023, 16383);

      phase_no = 0;
      while (random_items < ITEM_GOAL) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         case (phase_no)
            0: pick = 0;
            1: pick = 1;
            2: pick = 2;
            default: pick = $urandom_range(0, 6);
         endcase
         if (pick == 1) wide_phase(phase_no == 1);
         else if (pick == 2 && last_build_n >= 3) shrink_phase();
         else tree_phase();
         phase_no++;
      end

      settle();
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
